>>> sv/apsr_pkg.sv
// ----------------------------------------------------------------------------
// apsr_pkg: shared types and codes for the analog pad serial responder
// Item structs, the responder state struct, command codes and protocol bytes.
// ----------------------------------------------------------------------------
package apsr_pkg;

    // input item event kinds
    localparam logic [1:0] MODE_XCHG  = 2'd0;
    localparam logic [1:0] MODE_END   = 2'd1;
    localparam logic [1:0] MODE_TOGGLE = 2'd2;

    // command sequencer codes
    localparam logic [3:0] CMD_IDLE    = 4'd0;
    localparam logic [3:0] CMD_READY   = 4'd1;
    localparam logic [3:0] CMD_READ    = 4'd2;
    localparam logic [3:0] CMD_CFGMODE = 4'd3;
    localparam logic [3:0] CMD_SETANA  = 4'd4;
    localparam logic [3:0] CMD_GETANA  = 4'd5;
    localparam logic [3:0] CMD_INFO46  = 4'd6;
    localparam logic [3:0] CMD_INFO47  = 4'd7;
    localparam logic [3:0] CMD_INFO4C  = 4'd8;
    localparam logic [3:0] CMD_RUMBLE  = 4'd9;

    // host command bytes
    localparam logic [7:0] BYTE_ADDR    = 8'h01;
    localparam logic [7:0] BYTE_READ    = 8'h42;
    localparam logic [7:0] BYTE_CFG     = 8'h43;
    localparam logic [7:0] BYTE_SETANA  = 8'h44;
    localparam logic [7:0] BYTE_GETANA  = 8'h45;
    localparam logic [7:0] BYTE_INFO46  = 8'h46;
    localparam logic [7:0] BYTE_INFO47  = 8'h47;
    localparam logic [7:0] BYTE_INFO4C  = 8'h4C;
    localparam logic [7:0] BYTE_RUMBLE  = 8'h4D;

    localparam logic [7:0] STATUS_RESET = 8'h5A;
    localparam logic [7:0] IDLE_BYTE    = 8'hFF;
    localparam logic [2:0] SLOT_NONE    = 3'd7;
    localparam logic [7:0] STICK_LOW    = 8'd64;
    localparam logic [7:0] STICK_HIGH   = 8'd191;

    // configuration register addresses
    localparam logic [2:0] ADDR_DPAD  = 3'd0;
    localparam logic [2:0] ADDR_EXTRA = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  rx_byte;
        logic [15:0] buttons;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
    } in_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       ack;
        logic [7:0] large_motor;
        logic [7:0] small_motor;
        logic       analog_on;
        logic       config_on;
    } out_t;

    typedef struct packed {
        logic [3:0]      cmd;
        logic [2:0]      step;
        logic [3:0]      len;
        logic [7:0][7:0] recv;
        logic [7:0][7:0] reply;
        logic            analog;
        logic            cfg;
        logic            ext;
        logic            locked;
        logic            pending;
        logic [7:0]      status;
        logic [5:0][7:0] rmap;
        logic [2:0]      lslot;
        logic [2:0]      sslot;
        logic [7:0]      lmot;
        logic [7:0]      smot;
    } state_t;

endpackage

>>> sv/analog_pad_serial_responder_top.sv
// ----------------------------------------------------------------------------
// analog_pad_serial_responder_top: device side of a game-pad serial exchange
// Answers host bytes, transfer ends and mode toggles with one reply item each.
// ----------------------------------------------------------------------------
// Every input item yields exactly one result item, registered in the cycle
// after it is accepted. The whole reply decision is one pass of mux logic from the state
// registers to the result register, so one item is taken per clock; input
// stalls only while a result sits in the output register and the sink stalls.
// Configuration (d-pad emulation enable at 0x0, extra digital halfwords at 0x4)
// is to be written through the APB port while no item is in flight; the block does not enforce this.
module analog_pad_serial_responder_top
    import apsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t     st_reg;
    state_t     st_next;
    out_t       out_reg;
    out_t       res;
    logic       out_valid_reg;
    logic       dpad_reg;
    logic [1:0] extra_reg;
    logic       accept;
    logic       cfg_wr;

    // power-up pad state: idle, status byte set, no rumble slots mapped
    function automatic state_t reset_state();
        state_t r;
        r        = '0;
        r.cmd    = CMD_IDLE;
        r.status = STATUS_RESET;
        r.rmap   = '1;
        r.lslot  = SLOT_NONE;
        r.sslot  = SLOT_NONE;
        return r;
    endfunction

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign prdata    = paddr[2] ? {30'd0, extra_reg} : {31'd0, dpad_reg};

    apsr_step u_step (
        .st      (st_reg),
        .item    (in_data),
        .dpad_en (dpad_reg),
        .extra   (extra_reg),
        .nx      (st_next),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpad_reg  <= 1'b1;
            extra_reg <= 2'd0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == ADDR_EXTRA[2])
                extra_reg <= pwdata[1:0];
            else
                dpad_reg <= pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= reset_state();
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
                st_reg <= st_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // hold the result while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= res;
    end

    a_ack_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.ack) |-> (st_reg.cmd != CMD_IDLE))
        else $error("ack shown while sequencer idle");

    a_small_motor : assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.smot == 8'd0) || (st_reg.smot == 8'd255))
        else $error("small motor level not on/off");

    a_cfg_ext : assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.cfg |-> st_reg.ext)
        else $error("config mode without extended enable");

    a_len : assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.len == 4'd0) || (st_reg.len == 4'd4) || (st_reg.len == 4'd6)
        || (st_reg.len == 4'd8))
        else $error("bad reply length");

endmodule

>>> sv/apsr_step.sv
// ----------------------------------------------------------------------------
// apsr_step: next-state and reply logic for one item
// Decodes the event, advances the command sequencer and forms the result.
// ----------------------------------------------------------------------------
module apsr_step
    import apsr_pkg::*;
(
    input  state_t     st,
    input  in_t        item,
    input  logic       dpad_en,
    input  logic [1:0] extra,
    output state_t     nx,
    output out_t       res
);

    function automatic state_t clear_rumble(state_t s);
        state_t r;
        r = s;
        r.rmap  = '1;
        r.lslot = SLOT_NONE;
        r.sslot = SLOT_NONE;
        r.lmot  = '0;
        r.smot  = '0;
        return r;
    endfunction

    function automatic state_t flip(state_t s);
        state_t r;
        r = s;
        if (!s.locked)
        begin
            r = clear_rumble(s);
            r.analog = ~s.analog;
            if (s.ext)
            begin
                r.status = '0;
            end
        end
        return r;
    endfunction

    logic [2:0] step;
    logic [7:0] d;
    logic       full;
    logic [1:0] hw;
    logic [3:0] len;
    logic [7:0] id;
    logic [7:0] mask;
    logic       pad_en;
    logic [7:0] pad_val;
    logic [2:0] idx;
    logic       early;
    logic       start;
    logic [3:0] new_cmd;
    logic [3:0] s1;
    logic [3:0] nstep;

    always_comb
    begin
        step = st.step;
        d    = item.rx_byte;
        full = st.cfg | st.analog;
        hw   = full ? 2'd3 : ((extra > 2'd2) ? 2'd3 : extra + 2'd1);
        len  = {({1'b0, hw} + 3'd1), 1'b0};
        id   = {(st.cfg ? 4'hF : (st.analog ? 4'h7 : 4'h4)), 2'b00, hw};
        idx  = step - 3'd2;

        // d-pad from left stick, active low
        mask = 8'hFF;
        if (dpad_en && !full)
        begin
            mask[7] = ~(item.left_x <= STICK_LOW);
            mask[5] = ~(item.left_x >= STICK_HIGH);
            mask[4] = ~(item.left_y <= STICK_LOW);
            mask[6] = ~(item.left_y >= STICK_HIGH);
        end

        pad_en  = 1'b0;
        pad_val = '0;
        case (step)
            3'd2:
            begin
                pad_en  = 1'b1;
                pad_val = item.buttons[7:0] & mask;
            end
            3'd3:
            begin
                pad_en  = 1'b1;
                pad_val = item.buttons[15:8];
            end
            3'd4:
            begin
                pad_en  = full;
                pad_val = item.right_x;
            end
            3'd5:
            begin
                pad_en  = full;
                pad_val = item.right_y;
            end
            3'd6:
            begin
                pad_en  = full;
                pad_val = item.left_x;
            end
            3'd7:
            begin
                pad_en  = full;
                pad_val = item.left_y;
            end
            default:
            begin
                pad_en = 1'b0;
            end
        endcase

        nx      = st;
        early   = 1'b0;
        start   = 1'b0;
        new_cmd = CMD_IDLE;
        s1      = '0;
        nstep   = '0;
        res.tx_byte = IDLE_BYTE;
        res.ack     = 1'b0;

        case (item.mode)
            MODE_XCHG:
            begin
                nx.recv[step] = d;
                case (st.cmd)
                    CMD_READY:
                    begin
                        start = 1'b1;
                        if (d == BYTE_READ)
                            new_cmd = CMD_READ;
                        else if (d == BYTE_CFG)
                            new_cmd = CMD_CFGMODE;
                        else if (st.cfg && d == BYTE_SETANA)
                            new_cmd = CMD_SETANA;
                        else if (st.cfg && d == BYTE_GETANA)
                            new_cmd = CMD_GETANA;
                        else if (st.cfg && d == BYTE_INFO46)
                            new_cmd = CMD_INFO46;
                        else if (st.cfg && d == BYTE_INFO47)
                            new_cmd = CMD_INFO47;
                        else if (st.cfg && d == BYTE_INFO4C)
                            new_cmd = CMD_INFO4C;
                        else if (st.cfg && d == BYTE_RUMBLE)
                            new_cmd = CMD_RUMBLE;
                        else
                            start = 1'b0;
                        if (start)
                        begin
                            nx.reply    = '0;
                            nx.len      = len;
                            nx.cmd      = new_cmd;
                            nx.reply[0] = id;
                            nx.reply[1] = st.status;
                            case (new_cmd)
                                CMD_SETANA:
                                begin
                                    nx = clear_rumble(nx);
                                end
                                CMD_GETANA:
                                begin
                                    nx.reply[2] = 8'd1;
                                    nx.reply[3] = 8'd2;
                                    nx.reply[4] = {7'd0, st.analog};
                                    nx.reply[5] = 8'd2;
                                    nx.reply[6] = 8'd1;
                                end
                                CMD_INFO47:
                                begin
                                    nx.reply[4] = 8'd2;
                                    nx.reply[6] = 8'd1;
                                end
                                CMD_RUMBLE:
                                begin
                                    nx.lslot = SLOT_NONE;
                                    nx.sslot = SLOT_NONE;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        else
                        begin
                            early = 1'b1;
                        end
                    end
                    CMD_READ:
                    begin
                        if (pad_en)
                            nx.reply[step] = pad_val;
                        if (step >= 3'd2)
                        begin
                            if (st.ext)
                            begin
                                if (st.sslot == idx)
                                    nx.smot = {8{d[0]}};
                                else if (st.lslot == idx)
                                    nx.lmot = d;
                            end
                            else if (step == 3'd3)
                            begin
                                // legacy rumble: small motor on 0x40-class byte 2, bit 0 of byte 3
                                nx.smot = {8{(nx.recv[2][7:6] == 2'b01) && nx.recv[3][0]}};
                            end
                        end
                    end
                    CMD_CFGMODE:
                    begin
                        if (!st.cfg && pad_en)
                            nx.reply[step] = pad_val;
                        if ({1'b0, step} + 4'd1 == st.len)
                        begin
                            nx.cfg = (nx.recv[2] == 8'd1);
                            if (nx.recv[2] == 8'd1)
                            begin
                                nx.ext    = 1'b1;
                                nx.status = STATUS_RESET;
                            end
                        end
                    end
                    CMD_SETANA:
                    begin
                        if (step == 3'd2 && d <= 8'd1)
                            nx.analog = d[0];
                        else if (step == 3'd3 && (d == 8'd2 || d == 8'd3))
                            nx.locked = d[0];
                    end
                    CMD_GETANA:
                    begin
                    end
                    CMD_INFO46:
                    begin
                        if (step == 3'd2 && d == 8'd0)
                        begin
                            nx.reply[4] = 8'd1;
                            nx.reply[5] = 8'd2;
                            nx.reply[6] = 8'd0;
                            nx.reply[7] = 8'h0A;
                        end
                        else if (step == 3'd2 && d == 8'd1)
                        begin
                            nx.reply[4] = 8'd1;
                            nx.reply[5] = 8'd1;
                            nx.reply[6] = 8'd1;
                            nx.reply[7] = 8'h14;
                        end
                    end
                    CMD_INFO47:
                    begin
                        if (step == 3'd2 && d != 8'd0)
                        begin
                            nx.reply[4] = '0;
                            nx.reply[5] = '0;
                            nx.reply[6] = '0;
                            nx.reply[7] = '0;
                        end
                    end
                    CMD_INFO4C:
                    begin
                        if (step == 3'd2 && d == 8'd0)
                            nx.reply[5] = 8'd4;
                        else if (step == 3'd2 && d == 8'd1)
                            nx.reply[5] = 8'd7;
                    end
                    CMD_RUMBLE:
                    begin
                        if (step >= 3'd2)
                        begin
                            nx.reply[step] = st.rmap[idx];
                            nx.rmap[idx]   = d;
                            if (d == 8'd0)
                                nx.sslot = idx;
                            else if (d == 8'd1)
                                nx.lslot = idx;
                        end
                        if (step == 3'd7)
                        begin
                            if (nx.lslot == SLOT_NONE)
                                nx.lmot = '0;
                            if (nx.sslot == SLOT_NONE)
                                nx.smot = '0;
                        end
                    end
                    default:
                    begin
                        // wait for the address byte
                        nx.cmd  = (d == BYTE_ADDR) ? CMD_READY : CMD_IDLE;
                        res.ack = (d == BYTE_ADDR);
                        early   = 1'b1;
                    end
                endcase

                if (!early)
                begin
                    res.tx_byte = nx.reply[step];
                    s1 = {1'b0, step} + 4'd1;
                    if (nx.len == 4'd0)
                        nstep = '0;
                    else if (s1 >= nx.len)
                        nstep = s1 - nx.len;
                    else
                        nstep = s1;
                    nx.step = nstep[2:0];
                    res.ack = (nstep != 4'd0);
                    if (nstep == 4'd0)
                    begin
                        nx.cmd   = CMD_IDLE;
                        nx.recv  = '0;
                        nx.reply = '0;
                    end
                end
            end
            MODE_END:
            begin
                if (st.pending)
                    nx = flip(st);
                nx.pending = 1'b0;
                nx.cmd     = CMD_IDLE;
                nx.step    = '0;
            end
            MODE_TOGGLE:
            begin
                // queue the toggle while a command is running
                if (st.cmd == CMD_IDLE)
                    nx = flip(st);
                else
                    nx.pending = 1'b1;
            end
            default:
            begin
            end
        endcase

        res.large_motor = nx.lmot;
        res.small_motor = nx.smot;
        res.analog_on   = nx.analog;
        res.config_on   = nx.cfg;
    end

endmodule

>>> sim/apsr_checker.sv
// ----------------------------------------------------------------------------
// apsr_checker: reply predictor and scoreboard for the pad serial responder
// Watches both item channels, works out each expected reply from its own copy
// of the pad state and compares every result item as a whole.
// ----------------------------------------------------------------------------
module apsr_checker
    import apsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_t         in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_t        out_data,
    input  logic        cfg_dpad,
    input  logic [1:0]  cfg_extra,
    output int          fail_count,
    output int          pending_replies
);

    logic [3:0]      cmd;
    logic [2:0]      step;
    logic [3:0]      len;
    logic [7:0][7:0] recv;
    logic [7:0][7:0] reply;
    logic            analog;
    logic            cfg;
    logic            ext;
    logic            locked;
    logic            pending;
    logic [7:0]      status;
    logic [5:0][7:0] rmap;
    logic [2:0]      lslot;
    logic [2:0]      sslot;
    logic [7:0]      lmot;
    logic [7:0]      smot;

    out_t reply_queue[$];

    assign pending_replies = reply_queue.size();

    task automatic clear_rumble();
        rmap  = '1;
        lslot = SLOT_NONE;
        sslot = SLOT_NONE;
        lmot  = '0;
        smot  = '0;
    endtask

    task automatic flip_mode();
        if (!locked)
        begin
            analog = !analog;
            clear_rumble();
            if (ext)
                status = 8'h00;
        end
    endtask

    function automatic int halfwords();
        if (cfg || analog)
            return 3;
        return 1 + ((cfg_extra > 2) ? 2 : int'(cfg_extra));
    endfunction

    function automatic logic [7:0] dpad_mask(logic [7:0] lx, logic [7:0] ly);
        logic [7:0] m;
        m = '0;
        if (!cfg_dpad || analog || cfg)
            return 8'hFF;
        if (lx <= STICK_LOW)  m[7] = 1'b1;
        if (lx >= STICK_HIGH) m[5] = 1'b1;
        if (ly <= STICK_LOW)  m[4] = 1'b1;
        if (ly >= STICK_HIGH) m[6] = 1'b1;
        return ~m;
    endfunction

    task automatic pad_bytes(int s, in_t it);
        logic full;
        full = cfg || analog;
        case (s)
            2: reply[2] = it.buttons[7:0] & dpad_mask(it.left_x, it.left_y);
            3: reply[3] = it.buttons[15:8];
            4: if (full) reply[4] = it.right_x;
            5: if (full) reply[5] = it.right_y;
            6: if (full) reply[6] = it.left_x;
            7: if (full) reply[7] = it.left_y;
            default: ;
        endcase
    endtask

    task automatic start_reply(logic [3:0] c);
        logic [3:0] idn;
        reply = '0;
        len   = 4'((halfwords() + 1) * 2);
        cmd   = c;
        idn   = cfg ? 4'hF : (analog ? 4'h7 : 4'h4);
        reply[0] = {idn, 4'(halfwords())};
        reply[1] = status;
    endtask

    task automatic drive_slot(int idx, logic [7:0] v);
        if (sslot == idx)
            smot = v[0] ? 8'hFF : 8'h00;
        else if (lslot == idx)
            lmot = v;
    endtask

    // one host byte; returns reply byte and ack
    task automatic exchange(in_t it, output logic [7:0] tx, output logic ack);
        int s;
        logic [7:0] d;
        logic handled;
        s = step;
        d = it.rx_byte;
        recv[s] = d;
        ack = 1'b0;
        tx = IDLE_BYTE;
        handled = 1'b1;
        case (cmd)
            CMD_READY:
            begin
                if (d == BYTE_READ) start_reply(CMD_READ);
                else if (d == BYTE_CFG) start_reply(CMD_CFGMODE);
                else if (cfg && d == BYTE_SETANA)
                begin
                    start_reply(CMD_SETANA);
                    clear_rumble();
                end
                else if (cfg && d == BYTE_GETANA)
                begin
                    start_reply(CMD_GETANA);
                    reply[2] = 1; reply[3] = 2; reply[4] = {7'd0, analog};
                    reply[5] = 2; reply[6] = 1;
                end
                else if (cfg && d == BYTE_INFO46) start_reply(CMD_INFO46);
                else if (cfg && d == BYTE_INFO47)
                begin
                    start_reply(CMD_INFO47);
                    reply[4] = 2; reply[6] = 1;
                end
                else if (cfg && d == BYTE_INFO4C) start_reply(CMD_INFO4C);
                else if (cfg && d == BYTE_RUMBLE)
                begin
                    start_reply(CMD_RUMBLE);
                    lslot = SLOT_NONE;
                    sslot = SLOT_NONE;
                end
                else
                    return;
            end
            CMD_READ:
            begin
                pad_bytes(s, it);
                if (s >= 2)
                begin
                    if (ext)
                        drive_slot(s - 2, d);
                    else if (s == 3)
                        smot = ((recv[2] & 8'hC0) == 8'h40 && recv[3][0]) ? 8'hFF : 8'h00;
                end
            end
            CMD_CFGMODE:
            begin
                if (!cfg)
                    pad_bytes(s, it);
                if (s + 1 == len)
                begin
                    cfg = (recv[2] == 8'd1);
                    if (cfg)
                    begin
                        ext = 1'b1;
                        status = STATUS_RESET;
                    end
                end
            end
            CMD_SETANA:
            begin
                if (s == 2 && d <= 1) analog = d[0];
                else if (s == 3 && (d == 2 || d == 3)) locked = (d == 3);
            end
            CMD_GETANA: ;
            CMD_INFO46:
            begin
                if (s == 2 && d == 0)
                begin
                    reply[4] = 1; reply[5] = 2; reply[6] = 0; reply[7] = 8'h0A;
                end
                else if (s == 2 && d == 1)
                begin
                    reply[4] = 1; reply[5] = 1; reply[6] = 1; reply[7] = 8'h14;
                end
            end
            CMD_INFO47:
                if (s == 2 && d != 0)
                begin
                    reply[4] = 0; reply[5] = 0; reply[6] = 0; reply[7] = 0;
                end
            CMD_INFO4C:
            begin
                if (s == 2 && d == 0) reply[5] = 4;
                else if (s == 2 && d == 1) reply[5] = 7;
            end
            CMD_RUMBLE:
            begin
                if (s >= 2)
                begin
                    reply[s] = rmap[s - 2];
                    rmap[s - 2] = d;
                    if (d == 0) sslot = 3'(s - 2);
                    else if (d == 1) lslot = 3'(s - 2);
                end
                if (s == 7)
                begin
                    if (lslot == SLOT_NONE) lmot = 0;
                    if (sslot == SLOT_NONE) smot = 0;
                end
            end
            default:
            begin
                handled = 1'b0;
                cmd = (d == BYTE_ADDR) ? CMD_READY : CMD_IDLE;
                ack = (d == BYTE_ADDR);
            end
        endcase
        if (!handled)
            return;
        tx = reply[s];
        s = (len != 0) ? (s + 1) % len : 0;
        step = 3'(s);
        ack = (s != 0);
        if (s == 0)
        begin
            cmd = CMD_IDLE;
            recv = '0;
            reply = '0;
        end
    endtask

    task automatic predict_reply(in_t it);
        out_t r;
        r = '0;
        r.tx_byte = IDLE_BYTE;
        case (it.mode)
            MODE_XCHG: exchange(it, r.tx_byte, r.ack);
            MODE_END:
            begin
                if (pending)
                begin
                    flip_mode();
                    pending = 1'b0;
                end
                cmd = CMD_IDLE;
                step = 0;
            end
            MODE_TOGGLE:
                if (cmd == CMD_IDLE)
                    flip_mode();
                else
                    pending = 1'b1;
            default: ;
        endcase
        r.large_motor = lmot;
        r.small_motor = smot;
        r.analog_on = analog;
        r.config_on = cfg;
        reply_queue.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            cmd = CMD_IDLE; step = 0; len = 0; recv = '0; reply = '0;
            analog = 0; cfg = 0; ext = 0; locked = 0; pending = 0;
            status = STATUS_RESET;
            clear_rumble();
            reply_queue.delete();
            fail_count <= 0;
        end
        else
        begin
            // check the result first; a new item's reply cannot leave this cycle
            if (out_valid && !out_stall)
            begin
                if (reply_queue.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result item %p", out_data);
                end
                else
                begin
                    want = reply_queue.pop_front();
                    if (want !== out_data)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected %p got %p", want, out_data);
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_reply(in_data);
        end
    end

endmodule

>>> sim/analog_pad_serial_responder_top_tb.sv
// ----------------------------------------------------------------------------
// analog_pad_serial_responder_top_tb: stimulus for the pad serial responder
// Runs directed host transfers, then random command sequences under several
// register settings with random idling on both channels in all but the last.
// ----------------------------------------------------------------------------
module analog_pad_serial_responder_top_tb;
    import apsr_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_stall = 0;
    out_t        out_data;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        cfg_dpad = 1;
    logic [1:0]  cfg_extra = 0;
    int          fail_count;
    int          pending_replies;
    int          cycle_count = 0;
    int          sent = 0;
    logic        calm = 0;

    always #5 clk = ~clk;

    analog_pad_serial_responder_top uut (.*);

    apsr_checker chk (
        .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
        .out_data, .cfg_dpad, .cfg_extra, .fail_count, .pending_replies
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // sink stalls in random bursts
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 15);
                out_stall <= 1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 0;
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending_replies != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_regs(logic d, logic [1:0] e);
        drain();
        reg_write(ADDR_DPAD, {31'd0, d});
        reg_write(ADDR_EXTRA, {30'd0, e});
        cfg_dpad = d;
        cfg_extra = e;
    endtask

    function automatic logic [7:0] stick();
        case ($urandom_range(0, 5))
            0: return 8'd64;
            1: return 8'd65;
            2: return 8'd190;
            3: return 8'd191;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send(logic [1:0] m, logic [7:0] b);
        in_t it;
        int n;
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 15);
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
        it.mode = m;
        it.rx_byte = b;
        it.buttons = 16'($urandom);
        it.left_x = stick();
        it.left_y = stick();
        it.right_x = 8'($urandom);
        it.right_y = 8'($urandom);
        in_valid <= 1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    // address byte, command byte, then the payload bytes of one transfer
    task automatic transfer(logic [7:0] c, int nbytes, logic [7:0] arg);
        send(MODE_XCHG, BYTE_ADDR);
        send(MODE_XCHG, c);
        for (int i = 0; i < nbytes; i++)
            send(MODE_XCHG, (i == 0) ? arg : 8'($urandom_range(0, 3)));
    endtask

    function automatic logic [7:0] pick_cmd();
        logic [7:0] cmds[9];
        cmds = '{BYTE_READ, BYTE_CFG, BYTE_SETANA, BYTE_GETANA, BYTE_INFO46,
                 BYTE_INFO47, BYTE_INFO4C, BYTE_RUMBLE, 8'($urandom)};
        return cmds[$urandom_range(0, 8)];
    endfunction

    task automatic random_phase(int items);
        int stop;
        stop = sent + items;
        while (sent < stop)
        begin
            case ($urandom_range(0, 9))
                0: send(MODE_END, 8'($urandom));
                1: send(MODE_TOGGLE, 8'($urandom));
                2: send(2'd3, 8'($urandom));
                3: send(MODE_XCHG, 8'($urandom));
                default:
                begin
                    // mostly whole transfers, sometimes cut short
                    transfer(pick_cmd(), $urandom_range(0, 8), 8'($urandom_range(0, 3)));
                    if ($urandom_range(0, 3) == 0)
                        send(MODE_END, 0);
                end
            endcase
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: read in digital mode, legacy rumble, config entry, info, rumble map, toggle, end
        transfer(BYTE_READ, 2, 8'h40);
        send(MODE_XCHG, 8'h00);
        send(MODE_XCHG, 8'hFF);
        transfer(BYTE_SETANA, 2, 8'h01);
        transfer(BYTE_CFG, 6, 8'h01);
        transfer(BYTE_SETANA, 6, 8'h01);
        transfer(BYTE_INFO46, 6, 8'h01);
        transfer(BYTE_RUMBLE, 6, 8'h00);
        send(MODE_TOGGLE, 0);
        send(MODE_END, 0);
        send(2'd3, 8'hFF);
        set_regs(0, 3);
        random_phase(300);
        set_regs(1, 2);
        random_phase(300);
        set_regs(0, 0);
        random_phase(300);
        set_regs(1, 1);
        calm = 1;
        random_phase(300);
        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> analog_pad_serial_responder_top.f
sv/apsr_pkg.sv
sv/apsr_step.sv
sv/analog_pad_serial_responder_top.sv
sim/apsr_checker.sv
sim/analog_pad_serial_responder_top_tb.sv
